// ===== design/vmd_pkg.sv =====
package vmd_pkg;

    // Fixed system constants
    localparam int SAMPLE_RATE     = 48000;
    localparam int RING_DEPTH      = 512;
    localparam int SINE_TABLE_SIZE = 1024;

    // Field and register widths
    localparam int SAMPLE_W  = 24;
    localparam int RATE_W    = 4;
    localparam int WIDTH_W   = 9;
    localparam int CNT_W     = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam int ADDR_W  = $clog2(RING_DEPTH);
    localparam int LEN_W   = $clog2(RING_DEPTH + 1);
    localparam int PHASE_W = RATE_W + CNT_W;

    // Constant dividers done as round-up reciprocal multiplies, exact for
    // any dividend below 2**P*_W.
    localparam int TURN_SCALE = 65536;
    localparam int P1_W  = $clog2(SAMPLE_RATE * SINE_TABLE_SIZE);
    localparam int K1    = P1_W + $clog2(SAMPLE_RATE);
    localparam int IDX_W = $clog2(SINE_TABLE_SIZE);
    localparam int P2_W  = $clog2(SINE_TABLE_SIZE * TURN_SCALE);
    localparam int K2    = P2_W + $clog2(SINE_TABLE_SIZE);

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 36;
    localparam int POW_W  = 17;
    localparam int LFO_W  = 16;
    localparam int FRAC_W = 8;

    localparam logic [MUL_W-1:0] RECIP1 =
        MUL_W'(((64'd1 << K1) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE));
    localparam logic [MUL_W-1:0] RECIP2 =
        MUL_W'(((64'd1 << K2) + 64'(SINE_TABLE_SIZE) - 64'd1) / 64'(SINE_TABLE_SIZE));

    // Odd polynomial for a quarter sine, Q16
    localparam int SIN_C1     = 102919;
    localparam int SIN_C3     = 42109;
    localparam int SIN_C5     = 4746;
    localparam int Q16_ONE    = 65536;
    localparam int QUARTER    = 16384;
    localparam int INTERP_ONE = 256;
    localparam int ROUND_HALF = 128;

    // Reset values of the registers
    localparam int RESET_RATE  = 5;
    localparam int RESET_WIDTH = 96;
    localparam int RESET_LEN   = (RESET_WIDTH + 2 > RING_DEPTH) ? RING_DEPTH
                                                                : RESET_WIDTH + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LFO_RATE = 1'b0,
        REG_WIDTH    = 1'b1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_NONE,
        ST_PHASE,
        ST_SCALE,
        ST_RECIP1,
        ST_TURN,
        ST_RECIP2,
        ST_SQUARE,
        ST_CUBE,
        ST_FIFTH,
        ST_TERM1,
        ST_TERM3,
        ST_TERM5,
        ST_LFO,
        ST_DELAY,
        ST_ADDR,
        ST_READ0,
        ST_READ1,
        ST_MIX1,
        ST_MIX0
    } step_t;

    typedef struct packed {
        step_t step;
        logic  take_in;
        logic  finish;
    } cmd_t;

endpackage

// ===== design/vmd_ctrl.sv =====
module vmd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output vmd_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    vmd_pkg::step_t step_reg, step_next;
    logic           out_valid_reg, out_valid_next;
    logic           take;
    logic           finish;

    function automatic vmd_pkg::step_t following(vmd_pkg::step_t s);
        vmd_pkg::step_t n;
        case (s)
            vmd_pkg::ST_PHASE:  n = vmd_pkg::ST_SCALE;
            vmd_pkg::ST_SCALE:  n = vmd_pkg::ST_RECIP1;
            vmd_pkg::ST_RECIP1: n = vmd_pkg::ST_TURN;
            vmd_pkg::ST_TURN:   n = vmd_pkg::ST_RECIP2;
            vmd_pkg::ST_RECIP2: n = vmd_pkg::ST_SQUARE;
            vmd_pkg::ST_SQUARE: n = vmd_pkg::ST_CUBE;
            vmd_pkg::ST_CUBE:   n = vmd_pkg::ST_FIFTH;
            vmd_pkg::ST_FIFTH:  n = vmd_pkg::ST_TERM1;
            vmd_pkg::ST_TERM1:  n = vmd_pkg::ST_TERM3;
            vmd_pkg::ST_TERM3:  n = vmd_pkg::ST_TERM5;
            vmd_pkg::ST_TERM5:  n = vmd_pkg::ST_LFO;
            vmd_pkg::ST_LFO:    n = vmd_pkg::ST_DELAY;
            vmd_pkg::ST_DELAY:  n = vmd_pkg::ST_ADDR;
            vmd_pkg::ST_ADDR:   n = vmd_pkg::ST_READ0;
            vmd_pkg::ST_READ0:  n = vmd_pkg::ST_READ1;
            vmd_pkg::ST_READ1:  n = vmd_pkg::ST_MIX1;
            vmd_pkg::ST_MIX1:   n = vmd_pkg::ST_MIX0;
            default:            n = vmd_pkg::ST_NONE;
        endcase
        return n;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign take     = s_tvalid && s_tready;
    // result register must be empty or draining this cycle
    assign finish   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_RUN;
                    step_next  = vmd_pkg::ST_PHASE;
                end
            end
            S_RUN:
            begin
                step_next = following(step_reg);
                if (step_reg == vmd_pkg::ST_MIX0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= vmd_pkg::ST_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd.step    = (state_reg == S_RUN) ? step_reg : vmd_pkg::ST_NONE;
        cmd.take_in = take;
        cmd.finish  = finish;
    end

endmodule

// ===== design/vmd_datapath.sv =====
module vmd_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  vmd_pkg::cmd_t                          cmd,
    input  logic signed [vmd_pkg::SAMPLE_W-1:0]    in_sample,
    input  logic                                   cfg_we,
    input  logic        [vmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [vmd_pkg::CFG_W-1:0]       cfg_data,
    output logic signed [vmd_pkg::SAMPLE_W-1:0]    out_sample
);

    localparam int AW = vmd_pkg::ADDR_W;
    localparam int LW = vmd_pkg::LEN_W;
    localparam int MW = vmd_pkg::MUL_W;
    localparam int PW = vmd_pkg::POW_W;
    localparam int CW = vmd_pkg::ACC_W;
    localparam int SW = vmd_pkg::SAMPLE_W;

    // control state
    logic [vmd_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic [LW-1:0]              len_reg, len_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic [LW-1:0]              fill_reg, fill_next;   // entries at or above read as zero
    logic [vmd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    // payload
    logic signed [SW-1:0]                 sample_reg;
    logic signed [vmd_pkg::PROD_W-1:0]    prod_reg;
    logic signed [CW-1:0]                 acc_reg, acc_next;
    logic [1:0]                           quad_reg, quad_next;
    logic [PW-1:0]                        u_reg, u_next;
    logic [PW-1:0]                        u2_reg, u2_next;
    logic [PW-1:0]                        u3_reg, u3_next;
    logic [PW-1:0]                        u5_reg, u5_next;
    logic [vmd_pkg::LFO_W-1:0]            lfo_reg, lfo_next;
    logic [AW-1:0]                        m_reg, m_next;
    logic [AW-1:0]                        m1_reg, m1_next;
    logic [vmd_pkg::FRAC_W-1:0]           frac_reg, frac_next;
    logic signed [SW-1:0]                 s0_reg, s0_next;
    logic signed [SW-1:0]                 out_reg;
    logic signed [SW-1:0]                 rdata_reg;
    logic signed [SW-1:0]                 mem [vmd_pkg::RING_DEPTH];

    logic signed [MW-1:0]                 mul_a, mul_b;
    logic signed [vmd_pkg::PROD_W-1:0]    product;

    logic [vmd_pkg::PHASE_W-1:0] phase;
    logic                        phase_over;
    logic [vmd_pkg::PHASE_W-1:0] phase_c;
    logic [15:0]                 turn;
    logic [14:0]                 xm;
    logic [PW-1:0]               power;
    logic signed [CW-1:0]        acc_sum;
    logic signed [CW-1:0]        sine_sh;
    logic [PW-1:0]               sine;
    logic [PW:0]                 lfo_wide;
    logic [AW-1:0]               w_eff;
    logic [AW-1:0]               wp_eff;
    logic [AW-1:0]               d_int;
    logic [LW:0]                 msum;
    logic [LW:0]                 m_full;
    logic [AW-1:0]               m_cur;
    logic [LW-1:0]               m_inc;
    logic [LW-1:0]               wp_inc;
    logic [AW-1:0]               rd_addr;
    logic signed [SW-1:0]        rd_m;
    logic signed [SW-1:0]        rd_m1;
    logic signed [CW-1:0]        mix_sum;
    logic [vmd_pkg::WIDTH_W:0]   lsum;
    logic [LW-1:0]               cfg_len;

    // LFO phase and sine evaluation
    always_comb
    begin
        phase      = prod_reg[vmd_pkg::PHASE_W-1:0];
        phase_over = (phase >= vmd_pkg::PHASE_W'(vmd_pkg::SAMPLE_RATE));
        phase_c    = phase_over ? '0 : phase;

        turn = prod_reg[vmd_pkg::K2 +: 16];
        // mirror the offset in the second and fourth quadrants
        xm   = turn[14] ? (15'(vmd_pkg::QUARTER) - {1'b0, turn[13:0]})
                        : {1'b0, turn[13:0]};
        power = prod_reg[16 +: PW];

        acc_sum = acc_reg + $signed(prod_reg[CW-1:0]);
        sine_sh = acc_sum >>> 16;
        if (acc_sum[CW-1])
        begin
            sine = '0;
        end
        else if (sine_sh > CW'(vmd_pkg::Q16_ONE))
        begin
            sine = PW'(vmd_pkg::Q16_ONE);
        end
        else
        begin
            sine = sine_sh[PW-1:0];
        end
        if (!quad_reg[1])
        begin
            lfo_wide = ((PW+1)'(vmd_pkg::Q16_ONE) + {1'b0, sine}) >> 1;
        end
        else
        begin
            lfo_wide = ((PW+1)'(vmd_pkg::Q16_ONE) - {1'b0, sine}) >> 1;
        end
    end

    // ring addressing
    always_comb
    begin
        w_eff  = AW'(len_reg - LW'(2));
        wp_eff = (LW'(wp_reg) >= len_reg) ? '0 : wp_reg;
        d_int  = prod_reg[16 +: AW];
        msum   = (LW+1)'(wp_eff) + (LW+1)'(1) + (LW+1)'(d_int);
        m_full = (msum >= (LW+1)'(len_reg)) ? (msum - (LW+1)'(len_reg)) : msum;
        m_cur  = AW'(m_full);
        m_inc  = LW'(m_cur) + LW'(1);
        wp_inc = LW'(wp_eff) + LW'(1);
        rd_addr = (cmd.step == vmd_pkg::ST_READ1) ? m1_reg : m_reg;
        rd_m    = (LW'(m_reg) < fill_reg) ? rdata_reg : '0;
        rd_m1   = (LW'(m1_reg) < fill_reg) ? rdata_reg : '0;
        mix_sum = acc_sum + CW'(vmd_pkg::ROUND_HALF);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            vmd_pkg::ST_PHASE:
            begin
                mul_a = MW'(rate_reg);
                mul_b = MW'(cnt_reg);
            end
            vmd_pkg::ST_SCALE:
            begin
                mul_a = MW'(phase_c);
                mul_b = MW'(vmd_pkg::SINE_TABLE_SIZE);
            end
            vmd_pkg::ST_RECIP1:
            begin
                mul_a = MW'(prod_reg[vmd_pkg::P1_W-1:0]);
                mul_b = vmd_pkg::RECIP1;
            end
            vmd_pkg::ST_TURN:
            begin
                mul_a = MW'(prod_reg[vmd_pkg::K1 +: vmd_pkg::IDX_W]);
                mul_b = MW'(vmd_pkg::TURN_SCALE);
            end
            vmd_pkg::ST_RECIP2:
            begin
                mul_a = MW'(prod_reg[vmd_pkg::P2_W-1:0]);
                mul_b = vmd_pkg::RECIP2;
            end
            vmd_pkg::ST_SQUARE:
            begin
                mul_a = MW'({xm, 2'b00});
                mul_b = MW'({xm, 2'b00});
            end
            vmd_pkg::ST_CUBE:
            begin
                mul_a = MW'(power);
                mul_b = MW'(u_reg);
            end
            vmd_pkg::ST_FIFTH:
            begin
                mul_a = MW'(power);
                mul_b = MW'(u2_reg);
            end
            vmd_pkg::ST_TERM1:
            begin
                mul_a = MW'(u_reg);
                mul_b = MW'(vmd_pkg::SIN_C1);
            end
            vmd_pkg::ST_TERM3:
            begin
                mul_a = MW'(u3_reg);
                mul_b = MW'(vmd_pkg::SIN_C3);
            end
            vmd_pkg::ST_TERM5:
            begin
                mul_a = MW'(u5_reg);
                mul_b = MW'(vmd_pkg::SIN_C5);
            end
            vmd_pkg::ST_DELAY:
            begin
                mul_a = MW'(w_eff);
                mul_b = MW'(lfo_reg);
            end
            vmd_pkg::ST_MIX1:
            begin
                mul_a = MW'(frac_reg);
                mul_b = MW'(rd_m1);
            end
            vmd_pkg::ST_MIX0:
            begin
                mul_a = MW'(10'(vmd_pkg::INTERP_ONE) - 10'(frac_reg));
                mul_b = MW'(s0_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // register updates
    always_comb
    begin
        rate_next = rate_reg;
        len_next  = len_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        quad_next = quad_reg;
        u_next    = u_reg;
        u2_next   = u2_reg;
        u3_next   = u3_reg;
        u5_next   = u5_reg;
        lfo_next  = lfo_reg;
        m_next    = m_reg;
        m1_next   = m1_reg;
        frac_next = frac_reg;
        s0_next   = s0_reg;

        lsum    = (vmd_pkg::WIDTH_W+1)'(cfg_data[vmd_pkg::WIDTH_W-1:0])
                + (vmd_pkg::WIDTH_W+1)'(2);
        cfg_len = (lsum >= (vmd_pkg::WIDTH_W+1)'(vmd_pkg::RING_DEPTH))
                ? LW'(vmd_pkg::RING_DEPTH) : LW'(lsum);

        if (cfg_we)
        begin
            case (cfg_index)
                vmd_pkg::REG_LFO_RATE:
                begin
                    rate_next = cfg_data[vmd_pkg::RATE_W-1:0];
                end
                vmd_pkg::REG_WIDTH:
                begin
                    // grown entries read as zero: keep the filled prefix within the new ring
                    len_next  = cfg_len;
                    wp_next   = '0;
                    fill_next = (fill_reg > cfg_len) ? cfg_len : fill_reg;
                end
                default:
                begin
                    rate_next = rate_reg;
                end
            endcase
        end

        case (cmd.step)
            vmd_pkg::ST_SCALE:
            begin
                cnt_next = phase_over ? '0 : cnt_reg + vmd_pkg::CNT_W'(1);
            end
            vmd_pkg::ST_SQUARE:
            begin
                quad_next = turn[15:14];
                u_next    = {xm, 2'b00};
            end
            vmd_pkg::ST_CUBE:
            begin
                u2_next = power;
            end
            vmd_pkg::ST_FIFTH:
            begin
                u3_next = power;
            end
            vmd_pkg::ST_TERM1:
            begin
                u5_next = power;
            end
            vmd_pkg::ST_TERM3:
            begin
                acc_next = $signed(prod_reg[CW-1:0]);
            end
            vmd_pkg::ST_TERM5:
            begin
                acc_next = acc_reg - $signed(prod_reg[CW-1:0]);
            end
            vmd_pkg::ST_LFO:
            begin
                lfo_next = (lfo_wide > (PW+1)'(16'hFFFF)) ? 16'hFFFF : lfo_wide[15:0];
            end
            vmd_pkg::ST_ADDR:
            begin
                m_next    = m_cur;
                m1_next   = (m_inc == len_reg) ? '0 : AW'(m_inc);
                frac_next = prod_reg[8 +: vmd_pkg::FRAC_W];
            end
            vmd_pkg::ST_READ1:
            begin
                s0_next = rd_m;
            end
            vmd_pkg::ST_MIX0:
            begin
                acc_next = $signed(prod_reg[CW-1:0]);
            end
            default:
            begin
                acc_next = acc_next;
            end
        endcase

        if (cmd.finish)
        begin
            wp_next   = (wp_inc == len_reg) ? '0 : AW'(wp_inc);
            fill_next = (wp_inc > fill_reg) ? wp_inc : fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= vmd_pkg::RATE_W'(vmd_pkg::RESET_RATE);
            len_reg  <= LW'(vmd_pkg::RESET_LEN);
            wp_reg   <= '0;
            fill_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            rate_reg <= rate_next;
            len_reg  <= len_next;
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            sample_reg <= in_sample;
        end
        if (cmd.step != vmd_pkg::ST_NONE)
        begin
            prod_reg <= product;
        end
        if (cmd.finish)
        begin
            out_reg <= mix_sum[8 +: SW];
        end
        acc_reg  <= acc_next;
        quad_reg <= quad_next;
        u_reg    <= u_next;
        u2_reg   <= u2_next;
        u3_reg   <= u3_next;
        u5_reg   <= u5_next;
        lfo_reg  <= lfo_next;
        m_reg    <= m_next;
        m1_reg   <= m1_next;
        frac_reg <= frac_next;
        s0_reg   <= s0_next;
    end

    // delay ring: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            mem[wp_eff] <= sample_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign out_sample = out_reg;

endmodule

// ===== design/vibrato_modulated_delay_unit.sv =====
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tdata[23:0]  in_sample (signed Q1.23)
// m_*       out        m_tvalid/m_tready   m_tdata[23:0]  out_sample (signed Q1.23)
// cfg_*     in         cfg_we              cfg_index: 0 lfo_rate_hz, 1 width_samples
//
// Each sample runs from input transfer to the result register through 18
// sequencer steps through one shared 33x33 multiplier and the single read port
// of the 512-entry delay ring, plus the write-back state; samples do not overlap.
// The input is taken only while the sequencer is idle; a finished sample waits in
// write-back until the result register drains. Reset is asynchronous; a fill mark
// makes never-written ring entries read as zero, so there is no clearing pass.
module vibrato_modulated_delay_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic signed [vmd_pkg::SAMPLE_W-1:0]    s_tdata,   // [23:0] in_sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic signed [vmd_pkg::SAMPLE_W-1:0]    m_tdata,   // [23:0] out_sample
    input  logic                                   cfg_we,
    input  logic        [vmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [vmd_pkg::CFG_W-1:0]       cfg_data
);

    vmd_pkg::cmd_t cmd;

    vmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    vmd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_sample  (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_sample (m_tdata)
    );

endmodule
